>>> hdl/head_follow_wheel_steering_defines.svh
// Assertion macros for the head-follow steering RTL.
`ifndef HEAD_FOLLOW_WHEEL_STEERING_DEFINES_SVH
`define HEAD_FOLLOW_WHEEL_STEERING_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HFWS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hfws property failed");

// Next-cycle implication, disabled during reset.
`define HFWS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("hfws property failed");

`endif

>>> hdl/hfws_pkg.sv
// Shared constants, codes and angle helpers for the head-follow steering block.
`default_nettype none

package hfws_pkg;

    localparam int CORDIC_STEPS_DEF    = 14;
    localparam int ANGLE_FRAC_BITS_DEF = 12;
    localparam int TABLE_LEN           = 20;

    localparam int IN_W      = 16;
    localparam int CMD_W     = 2;
    localparam int FLAG_W    = 2;
    localparam int SPEED_W   = 8;
    localparam int STATUS_W  = 3;
    localparam int GAIN_W    = 8;
    localparam int NEAR_W    = 15;
    localparam int LIMIT_W   = 14;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 15;

    // Digit-serial datapath of the vectoring unit.
    localparam int PRE_SH     = 8;
    localparam int DIGIT_W    = 4;
    localparam int XY_W_MIN   = 26;
    localparam int NUM_DIGITS = (XY_W_MIN + DIGIT_W - 1) / DIGIT_W;
    localparam int XY_W       = NUM_DIGITS * DIGIT_W;

    localparam logic [CMD_W-1:0] CMD_HEAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MODE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ESTOP   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_GESTURE = 2'd3;

    localparam logic [FLAG_W-1:0] FLAG_OFF = 2'd0;
    localparam logic [FLAG_W-1:0] FLAG_ON  = 2'd1;

    localparam logic [STATUS_W-1:0] STAT_NOT_FOLLOW = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_ANGLE      = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NEAR       = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_TURN       = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_STRAIGHT   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT_BAND = 3'd5;

    localparam logic [GAIN_W-1:0]  RST_TURN_GAIN     = 8'd10;
    localparam logic [SPEED_W-1:0] RST_MAX_SPEED     = 8'd20;
    localparam logic [SPEED_W-1:0] RST_STRAIGHT      = 8'd16;
    localparam logic [NEAR_W-1:0]  RST_NEAR_LIMIT    = 15'd1200;
    localparam logic [LIMIT_W-1:0] RST_ANGLE_LIMIT   = 14'd2048;
    localparam logic [LIMIT_W-1:0] RST_STRAIGHT_BAND = 14'd205;

    // atan(2^-i) in Q30
    localparam longint unsigned ATAN_Q30 [TABLE_LEN] = '{
        64'd843314857, 64'd497837829, 64'd263043837, 64'd133525159, 64'd67021687,
        64'd33543516,  64'd16775851,  64'd8388437,   64'd4194283,   64'd2097149,
        64'd1048576,   64'd524288,    64'd262144,    64'd131072,    64'd65536,
        64'd32768,     64'd16384,     64'd8192,      64'd4096,      64'd2048
    };
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // Round a Q30 angle to frac fraction bits.
    function automatic longint unsigned to_angle(input longint unsigned t,
                                                 input int unsigned frac);
        return (t + (64'd1 << (29 - frac))) >> (30 - frac);
    endfunction

endpackage

`default_nettype wire

>>> hdl/hfws_cordic.sv
// Digit-serial vectoring CORDIC: heading of (head_z, -head_x) in fixed-point radians.
`default_nettype none

module hfws_cordic import hfws_pkg::*; #(
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    localparam int ANG_W          = ANGLE_FRAC_BITS + 4
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic signed [IN_W-1:0]  head_x,
    input  wire logic signed [IN_W-1:0]  head_z,
    output logic                         done,
    output logic signed [ANG_W-1:0]      angle
);

    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam int DIG_W  = $clog2(NUM_DIGITS);
    localparam int EXT_W  = XY_W - IN_W - 1 - PRE_SH;
    localparam logic signed [ANG_W-1:0] PI_ANG =
        ANG_W'(to_angle(PI_Q30, ANGLE_FRAC_BITS));

    logic                     busy_reg;
    logic                     done_reg;
    logic [XY_W-1:0]          x_reg, x_next;
    logic [XY_W-1:0]          y_reg, y_next;
    logic signed [ANG_W-1:0]  acc_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [DIG_W-1:0]         dig_reg;
    logic                     cx_reg;
    logic                     cy_reg;

    logic signed [IN_W:0]     xin, yin, x0, y0;
    logic [XY_W-1:0]          x_load, y_load;
    logic signed [ANG_W-1:0]  acc_load;
    logic                     zero_in;

    logic [ANG_W-1:0]         step_tab [CORDIC_STEPS];
    logic signed [XY_W-1:0]   xsh, ysh;
    logic [DIGIT_W-1:0]       xs, ys, xd, yd;
    logic                     dir;
    logic                     cxi, cyi;
    logic [DIGIT_W:0]         xa, ya;
    logic                     last_dig, last_step;

    always_comb begin
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            step_tab[k] = ANG_W'(to_angle(ATAN_Q30[k], ANGLE_FRAC_BITS));
        end
    end

    // Pre-rotate into the right half plane.
    always_comb begin
        xin = {head_z[IN_W-1], head_z};
        yin = -{head_x[IN_W-1], head_x};
        zero_in = (head_x == '0) && (head_z == '0);
        if (xin < 0) begin
            x0 = -xin;
            y0 = -yin;
            acc_load = (yin >= 0) ? PI_ANG : -PI_ANG;
        end else begin
            x0 = xin;
            y0 = yin;
            acc_load = '0;
        end
        if (zero_in) begin
            acc_load = '0;
        end
        x_load = {{EXT_W{x0[IN_W]}}, x0, {PRE_SH{1'b0}}};
        y_load = {{EXT_W{y0[IN_W]}}, y0, {PRE_SH{1'b0}}};
    end

    // One digit of both shift-add updates per cycle.
    always_comb begin
        xsh = $signed(x_reg) >>> step_reg;
        ysh = $signed(y_reg) >>> step_reg;
        xs  = x_reg[dig_reg*DIGIT_W +: DIGIT_W];
        ys  = y_reg[dig_reg*DIGIT_W +: DIGIT_W];
        xd  = xsh[dig_reg*DIGIT_W +: DIGIT_W];
        yd  = ysh[dig_reg*DIGIT_W +: DIGIT_W];
        dir = ~y_reg[XY_W-1];
        cxi = (dig_reg == '0) ? ~dir : cx_reg;
        cyi = (dig_reg == '0) ? dir : cy_reg;
        xa  = {1'b0, xs} + {1'b0, (dir ? yd : ~yd)} + (DIGIT_W+1)'(cxi);
        ya  = {1'b0, ys} + {1'b0, (dir ? ~xd : xd)} + (DIGIT_W+1)'(cyi);
        x_next = x_reg;
        y_next = y_reg;
        x_next[dig_reg*DIGIT_W +: DIGIT_W] = xa[DIGIT_W-1:0];
        y_next[dig_reg*DIGIT_W +: DIGIT_W] = ya[DIGIT_W-1:0];
        last_dig  = (dig_reg == DIG_W'(NUM_DIGITS - 1));
        last_step = (step_reg == STEP_W'(CORDIC_STEPS - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= !zero_in;
                done_reg <= zero_in;
            end else if (busy_reg && last_dig && last_step) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= x_load;
            y_reg    <= y_load;
            acc_reg  <= acc_load;
            step_reg <= '0;
            dig_reg  <= '0;
        end else if (busy_reg) begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            cx_reg <= xa[DIGIT_W];
            cy_reg <= ya[DIGIT_W];
            if (last_dig) begin
                dig_reg  <= '0;
                step_reg <= step_reg + 1'b1;
                acc_reg  <= dir ? acc_reg + $signed(step_tab[step_reg])
                                : acc_reg - $signed(step_tab[step_reg]);
            end else begin
                dig_reg <= dig_reg + 1'b1;
            end
        end
    end

    assign done  = done_reg;
    assign angle = acc_reg;

endmodule

`default_nettype wire

>>> hdl/head_follow_wheel_steering.sv
// Head-following differential drive controller: top level.
//
// Input channel (s_valid/s_ready): one event word per handshake. cmd 0 is a
// head position, cmd 1 sets auto mode, cmd 2 sets estop, cmd 3 is a
// start/stop gesture. Flag events give no result.
// A head word while auto is on and estop is off gives one result word on
// the output channel (m_valid/m_ready): left and right speed and a status.
// Sequence: while following, a head word goes through the digit-serial
// CORDIC (ST_CORD), then the shift-add gain multiply (ST_MUL), then the
// output stage (ST_FIN). A head at the origin skips the CORDIC iterations.
// When not following, the word goes straight from ST_IDLE to ST_FIN.
// One word is in flight at a time; s_ready is high only between words.
// The result sits in an output register; a stalled receiver holds it and
// the block still takes the next input word, finishing its work up to the
// output register before waiting.
// Reset (aresetn low, synchronous) clears the mode, estop and follow flags,
// drops any pending result and restores the register defaults.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
`default_nettype none
`include "head_follow_wheel_steering_defines.svh"

module head_follow_wheel_steering import hfws_pkg::*; #(
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,

    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [CMD_W-1:0]        s_cmd,
    input  wire logic signed [IN_W-1:0]  s_head_x,
    input  wire logic signed [IN_W-1:0]  s_head_z,
    input  wire logic [FLAG_W-1:0]       s_flag_value,

    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [SPEED_W-1:0]           m_left_speed,
    output logic [SPEED_W-1:0]           m_right_speed,
    output logic [STATUS_W-1:0]          m_drive_status,

    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int ANG_W = ANGLE_FRAC_BITS + 4;
    localparam int CMP_W = (ANG_W > LIMIT_W) ? ANG_W : LIMIT_W;
    localparam int PW    = ANG_W + GAIN_W;
    localparam int SW    = PW + 1;
    localparam int MCNT_W = $clog2(GAIN_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CORD = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]              state_reg;
    logic                    auto_reg, estop_reg, follow_reg;
    logic [GAIN_W-1:0]       turn_gain_reg;
    logic [SPEED_W-1:0]      max_speed_reg;
    logic [SPEED_W-1:0]      straight_reg;
    logic [NEAR_W-1:0]       near_reg;
    logic [LIMIT_W-1:0]      angle_limit_reg;
    logic [LIMIT_W-1:0]      band_reg;

    logic signed [IN_W-1:0]  hz_reg;
    logic signed [PW-1:0]    prod_reg;
    logic [GAIN_W-1:0]       gain_sh_reg;
    logic [MCNT_W-1:0]       mcnt_reg;

    logic                    m_valid_reg;
    logic [SPEED_W-1:0]      left_reg, right_reg;
    logic [STATUS_W-1:0]     status_reg;

    logic                    accept;
    logic                    head_go;
    logic                    cord_start;
    logic                    cord_done;
    logic signed [ANG_W-1:0] th;
    logic                    out_free;

    logic [ANG_W-1:0]        ath;
    logic                    out_of_angle, too_near, in_band;
    logic signed [SW-1:0]    base, lsum, rsum, lv, rv;
    logic [SPEED_W-1:0]      left_next, right_next;
    logic [STATUS_W-1:0]     status_next;

    function automatic logic [SPEED_W-1:0] sat_speed(input logic signed [SW-1:0] v);
        logic [SPEED_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed(SW'(255))) begin
            r = '1;
        end else begin
            r = v[SPEED_W-1:0];
        end
        return r;
    endfunction

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign head_go    = accept && (s_cmd == CMD_HEAD) && auto_reg && !estop_reg;
    assign cord_start = head_go && follow_reg;
    assign out_free   = !m_valid_reg || m_ready;

    hfws_cordic #(
        .CORDIC_STEPS    (CORDIC_STEPS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cord_start),
        .head_x  (s_head_x),
        .head_z  (s_head_z),
        .done    (cord_done),
        .angle   (th)
    );

    always_comb begin
        ath          = (th < 0) ? ANG_W'(-th) : ANG_W'(th);
        out_of_angle = CMP_W'(ath) >= CMP_W'(angle_limit_reg);
        too_near     = hz_reg <= $signed({1'b0, near_reg});
        in_band      = CMP_W'(ath) <= CMP_W'(band_reg);
        base         = $signed(SW'(max_speed_reg)) <<< (ANGLE_FRAC_BITS - 1);
        lsum         = base - SW'(prod_reg);
        rsum         = base + SW'(prod_reg);
        lv           = lsum >>> ANGLE_FRAC_BITS;
        rv           = rsum >>> ANGLE_FRAC_BITS;
        left_next    = '0;
        right_next   = '0;
        if (!follow_reg) begin
            status_next = STAT_NOT_FOLLOW;
        end else if (out_of_angle) begin
            status_next = STAT_ANGLE;
        end else if (too_near) begin
            status_next = STAT_NEAR;
        end else if (!in_band) begin
            status_next = STAT_TURN;
            left_next   = sat_speed(lv);
            right_next  = sat_speed(rv);
        end else begin
            status_next = STAT_STRAIGHT;
            left_next   = straight_reg;
            right_next  = straight_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            auto_reg    <= 1'b0;
            estop_reg   <= 1'b0;
            follow_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                case (s_cmd)
                    CMD_MODE: begin
                        auto_reg <= (s_flag_value == FLAG_ON);
                    end
                    CMD_ESTOP: begin
                        estop_reg <= (s_flag_value == FLAG_ON);
                    end
                    CMD_GESTURE: begin
                        if (s_flag_value == FLAG_ON) begin
                            follow_reg <= 1'b1;
                        end else if (s_flag_value == FLAG_OFF) begin
                            follow_reg <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            if (state_reg == ST_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (head_go) begin
                        state_reg <= follow_reg ? ST_CORD : ST_FIN;
                    end
                end
                ST_CORD: begin
                    if (cord_done) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (mcnt_reg == MCNT_W'(GAIN_W - 1)) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            turn_gain_reg   <= RST_TURN_GAIN;
            max_speed_reg   <= RST_MAX_SPEED;
            straight_reg    <= RST_STRAIGHT;
            near_reg        <= RST_NEAR_LIMIT;
            angle_limit_reg <= RST_ANGLE_LIMIT;
            band_reg        <= RST_STRAIGHT_BAND;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_TURN_GAIN:     turn_gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_MAX_SPEED:     max_speed_reg   <= cfg_data[SPEED_W-1:0];
                REG_STRAIGHT:      straight_reg    <= cfg_data[SPEED_W-1:0];
                REG_NEAR_LIMIT:    near_reg        <= cfg_data[NEAR_W-1:0];
                REG_ANGLE_LIMIT:   angle_limit_reg <= cfg_data[LIMIT_W-1:0];
                REG_STRAIGHT_BAND: band_reg        <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Gain times heading, one gain bit per cycle, MSB first.
    always_ff @(posedge aclk) begin
        if (head_go) begin
            hz_reg <= s_head_z;
        end
        if (state_reg == ST_CORD && cord_done) begin
            prod_reg    <= '0;
            gain_sh_reg <= turn_gain_reg;
            mcnt_reg    <= '0;
        end else if (state_reg == ST_MUL) begin
            prod_reg    <= (prod_reg <<< 1) + (gain_sh_reg[GAIN_W-1] ? PW'(th) : PW'(0));
            gain_sh_reg <= {gain_sh_reg[GAIN_W-2:0], 1'b0};
            mcnt_reg    <= mcnt_reg + 1'b1;
        end
        if (state_reg == ST_FIN && out_free) begin
            left_reg   <= left_next;
            right_reg  <= right_next;
            status_reg <= status_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_left_speed   = left_reg;
    assign m_right_speed  = right_reg;
    assign m_drive_status = status_reg;

    `HFWS_ASSERT_IMP(a_stop_zero, aclk, aresetn, m_valid && (m_drive_status == STAT_NOT_FOLLOW || m_drive_status == STAT_ANGLE || m_drive_status == STAT_NEAR), m_left_speed == '0 && m_right_speed == '0)
    `HFWS_ASSERT_IMP(a_straight_equal, aclk, aresetn, m_valid && m_drive_status == STAT_STRAIGHT, m_left_speed == m_right_speed)
    `HFWS_ASSERT_NXT(a_head_busy, aclk, aresetn, head_go, state_reg != ST_IDLE)
    `HFWS_ASSERT_IMP(a_result_from_fin, aclk, aresetn, $rose(m_valid_reg), $past(state_reg) == ST_FIN)

endmodule

`default_nettype wire

>>> test/head_follow_wheel_steering_checker.sv
// Checker for the head-follow steering block: predicts each drive word and compares it.
`timescale 1ns / 1ps

module head_follow_wheel_steering_checker import hfws_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [CMD_W-1:0]           s_cmd,
    input  logic signed [IN_W-1:0]     s_head_x,
    input  logic signed [IN_W-1:0]     s_head_z,
    input  logic [FLAG_W-1:0]          s_flag_value,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [SPEED_W-1:0]         m_left_speed,
    input  logic [SPEED_W-1:0]         m_right_speed,
    input  logic [STATUS_W-1:0]        m_drive_status,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    output int                         mismatches,
    output int                         pending,
    output int                         drives_due
);

    localparam int STEPS = 14;
    localparam int FRAC  = 12;

    localparam longint ATAN_STEP_Q30 [STEPS] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516,  16775851,  8388437,   4194283,   2097149,
        1048576,   524288,    262144,    131072
    };
    localparam longint HALF_TURN_Q30 = 64'sd3373259426;

    typedef struct packed {
        logic [SPEED_W-1:0]  left;
        logic [SPEED_W-1:0]  right;
        logic [STATUS_W-1:0] status;
    } drive_t;

    drive_t drive_q[$];

    logic [GAIN_W-1:0]  gain;
    logic [SPEED_W-1:0] top_speed;
    logic [SPEED_W-1:0] cruise;
    logic [NEAR_W-1:0]  near_mm;
    logic [LIMIT_W-1:0] limit_q12;
    logic [LIMIT_W-1:0] band_q12;
    logic               auto_flag;
    logic               estopped;
    logic               following;

    int fails;
    int due;

    function automatic longint q30_round(longint a);
        return (a + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
    endfunction

    // vectoring CORDIC on a pre-scaled vector, angle in Q12 radians
    function automatic longint heading_q12(longint y, longint x);
        longint vx, vy, acc, sx, sy;
        vx = x * 256;
        vy = y * 256;
        acc = 0;
        if (vx == 0 && vy == 0)
            return 0;
        if (vx < 0) begin
            acc = (vy >= 0) ? q30_round(HALF_TURN_Q30) : -q30_round(HALF_TURN_Q30);
            vx = -vx;
            vy = -vy;
        end
        for (int i = 0; i < STEPS; i++) begin
            sx = vy >>> i;
            sy = vx >>> i;
            if (vy >= 0) begin
                vx += sx;
                vy -= sy;
                acc += q30_round(ATAN_STEP_Q30[i]);
            end else begin
                vx -= sx;
                vy += sy;
                acc -= q30_round(ATAN_STEP_Q30[i]);
            end
        end
        return acc;
    endfunction

    function automatic logic [SPEED_W-1:0] wheel_clamp(longint scaled);
        longint v;
        v = scaled >>> (FRAC + 1);
        if (v < 0)
            return '0;
        if (v > 255)
            return 8'd255;
        return v[SPEED_W-1:0];
    endfunction

    function automatic drive_t drive_for(logic signed [IN_W-1:0] hx,
                                         logic signed [IN_W-1:0] hz);
        longint th, ath, base2, turn2;
        drive_t d;
        d = '0;
        if (!following) begin
            d.status = STAT_NOT_FOLLOW;
        end else begin
            th = heading_q12(-longint'(hx), longint'(hz));
            ath = (th < 0) ? -th : th;
            if (ath >= longint'(limit_q12)) begin
                d.status = STAT_ANGLE;
            end else if (longint'(hz) <= longint'(near_mm)) begin
                d.status = STAT_NEAR;
            end else if (ath > longint'(band_q12)) begin
                d.status = STAT_TURN;
                base2 = longint'(top_speed) << FRAC;
                turn2 = 2 * longint'(gain) * th;
                d.left = wheel_clamp(base2 - turn2);
                d.right = wheel_clamp(base2 + turn2);
            end else begin
                d.status = STAT_STRAIGHT;
                d.left = cruise;
                d.right = cruise;
            end
        end
        return d;
    endfunction

    always @(posedge aclk) begin
        drive_t got, want;
        if (!aresetn) begin
            gain = RST_TURN_GAIN;
            top_speed = RST_MAX_SPEED;
            cruise = RST_STRAIGHT;
            near_mm = RST_NEAR_LIMIT;
            limit_q12 = RST_ANGLE_LIMIT;
            band_q12 = RST_STRAIGHT_BAND;
            auto_flag = 1'b0;
            estopped = 1'b0;
            following = 1'b0;
            drive_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_TURN_GAIN:     gain = cfg_data[GAIN_W-1:0];
                    REG_MAX_SPEED:     top_speed = cfg_data[SPEED_W-1:0];
                    REG_STRAIGHT:      cruise = cfg_data[SPEED_W-1:0];
                    REG_NEAR_LIMIT:    near_mm = cfg_data[NEAR_W-1:0];
                    REG_ANGLE_LIMIT:   limit_q12 = cfg_data[LIMIT_W-1:0];
                    REG_STRAIGHT_BAND: band_q12 = cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                case (s_cmd)
                    CMD_MODE:  auto_flag = (s_flag_value == FLAG_ON);
                    CMD_ESTOP: estopped = (s_flag_value == FLAG_ON);
                    CMD_GESTURE: begin
                        if (s_flag_value == FLAG_ON)
                            following = 1'b1;
                        else if (s_flag_value == FLAG_OFF)
                            following = 1'b0;
                    end
                    default: begin
                        if (auto_flag && !estopped) begin
                            drive_q.push_back(drive_for(s_head_x, s_head_z));
                            due++;
                        end
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                got = '{m_left_speed, m_right_speed, m_drive_status};
                if (drive_q.size() == 0) begin
                    $error("m_drive_status: expected no word, actual %0d", got.status);
                    fails++;
                end else begin
                    want = drive_q.pop_front();
                    if (got.left !== want.left) begin
                        $error("m_left_speed: expected %0d, actual %0d", want.left, got.left);
                        fails++;
                    end
                    if (got.right !== want.right) begin
                        $error("m_right_speed: expected %0d, actual %0d",
                               want.right, got.right);
                        fails++;
                    end
                    if (got.status !== want.status) begin
                        $error("m_drive_status: expected %0d, actual %0d",
                               want.status, got.status);
                        fails++;
                    end
                end
            end
        end
        mismatches <= fails;
        pending <= drive_q.size();
        drives_due <= due;
    end

endmodule

>>> test/tb_head_follow_wheel_steering.sv
// Testbench top for the head-follow steering block: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module tb_head_follow_wheel_steering;
    import hfws_pkg::*;

    localparam int SETTLE_CYCLES = 130;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASES        = 8;
    localparam int PHASE_WORDS   = 200;

    localparam logic [FLAG_W-1:0] FLAG_KEEP  = 2'd2;
    localparam logic [FLAG_W-1:0] FLAG_SPARE = 2'd3;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [CMD_W-1:0]           s_cmd = CMD_HEAD;
    logic signed [IN_W-1:0]     s_head_x = '0;
    logic signed [IN_W-1:0]     s_head_z = '0;
    logic [FLAG_W-1:0]          s_flag_value = FLAG_OFF;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [SPEED_W-1:0]         m_left_speed;
    logic [SPEED_W-1:0]         m_right_speed;
    logic [STATUS_W-1:0]        m_drive_status;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = REG_TURN_GAIN;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;

    int mismatches;
    int pending;
    int drives_due;
    int cycles = 0;
    int words_sent = 0;
    int settings = 0;
    bit steady = 1'b0;

    always #1 aclk = ~aclk;

    head_follow_wheel_steering dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_head_x       (s_head_x),
        .s_head_z       (s_head_z),
        .s_flag_value   (s_flag_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_left_speed   (m_left_speed),
        .m_right_speed  (m_right_speed),
        .m_drive_status (m_drive_status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    head_follow_wheel_steering_checker drive_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_head_x       (s_head_x),
        .s_head_z       (s_head_z),
        .s_flag_value   (s_flag_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_left_speed   (m_left_speed),
        .m_right_speed  (m_right_speed),
        .m_drive_status (m_drive_status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .pending        (pending),
        .drives_due     (drives_due)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic signed [IN_W-1:0] hx,
                             input logic signed [IN_W-1:0] hz, input logic [FLAG_W-1:0] fv);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_head_x <= hx;
        s_head_z <= hz;
        s_flag_value <= fv;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    task automatic send_head(input int hx, input int hz);
        send_word(CMD_HEAD, hx[IN_W-1:0], hz[IN_W-1:0], FLAG_W'($urandom_range(0, 3)));
    endtask

    task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [FLAG_W-1:0] fv);
        send_word(cmd, IN_W'($urandom_range(0, 16'hFFFF)), IN_W'($urandom_range(0, 16'hFFFF)),
                  fv);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge aclk);
    endtask

    task automatic program_regs(input int gain, input int top, input int cruise,
                                input int near, input int lim, input int band);
        settle();
        write_reg(REG_TURN_GAIN, gain);
        write_reg(REG_MAX_SPEED, top);
        write_reg(REG_STRAIGHT, cruise);
        write_reg(REG_NEAR_LIMIT, near);
        write_reg(REG_ANGLE_LIMIT, lim);
        write_reg(REG_STRAIGHT_BAND, band);
        // out-of-range index must leave every register alone
        write_reg(CFG_IDX_W'(REG_STRAIGHT_BAND + 1 + $urandom_range(0, 1)),
                  $urandom_range(0, 16'h7FFF));
        cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic arm_follow();
        send_event(CMD_MODE, FLAG_ON);
        send_event(CMD_ESTOP, FLAG_OFF);
        send_event(CMD_GESTURE, FLAG_ON);
    endtask

    task automatic random_head(input int near);
        int kind, hx, hz;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3, 4, 5: begin
                hx = $urandom_range(0, 6000) - 3000;
                hz = near + $urandom_range(1, 6000);
            end
            6: begin
                hx = $urandom_range(0, 16'hFFFF) - 32768;
                hz = $urandom_range(0, 16'hFFFF) - 32768;
            end
            7: begin
                hx = $urandom_range(0, 400) - 200;
                hz = near + $urandom_range(0, 2) - 1;
            end
            8: begin
                hx = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 4000) - 2000;
                hz = ($urandom_range(0, 1) == 0) ? 0 : -$urandom_range(0, 32768);
            end
            default: begin
                hx = $urandom_range(0, 16'hFFFF) - 32768;
                hz = $urandom_range(0, 3000);
            end
        endcase
        if (hz > 32767)
            hz = 32767;
        send_head(hx, hz);
    endtask

    // result side: random stall before taking each word
    initial begin
        int stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        int near, lim, band, target, r, count;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: register defaults, flag handling and corner headings
        send_head(100, 2000);
        send_event(CMD_MODE, FLAG_ON);
        send_head(-500, 3000);
        send_event(CMD_ESTOP, FLAG_ON);
        send_head(0, 2000);
        send_event(CMD_ESTOP, FLAG_SPARE);
        send_event(CMD_GESTURE, FLAG_ON);
        send_head(0, 0);
        send_head(0, -100);
        send_head(-32768, 32767);
        send_head(32767, 32767);
        send_head(0, 32767);
        send_head(-300, 2000);
        send_head(400, 1201);
        send_head(100, 1200);
        send_head(32767, -32768);
        send_head(-32768, -32768);
        send_event(CMD_GESTURE, FLAG_KEEP);
        send_event(CMD_GESTURE, FLAG_SPARE);
        send_head(-200, 2500);
        send_event(CMD_MODE, FLAG_SPARE);
        send_head(50, 2000);
        send_event(CMD_MODE, FLAG_ON);
        send_event(CMD_GESTURE, FLAG_OFF);
        send_head(50, 2000);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: program_regs(0, 0, 0, 0, 0, 0);
                1: program_regs(255, 255, 255, 32767, 12868, 12868);
                2: program_regs(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
                3: program_regs(RST_TURN_GAIN, RST_MAX_SPEED, RST_STRAIGHT, RST_NEAR_LIMIT,
                                RST_ANGLE_LIMIT, RST_STRAIGHT_BAND);
                default: begin
                    lim = $urandom_range(200, 12868);
                    band = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12868)
                                                       : $urandom_range(0, lim);
                    program_regs($urandom_range(0, 255), $urandom_range(0, 255),
                                 $urandom_range(0, 255), $urandom_range(0, 3000), lim, band);
                end
            endcase
            near = (phase == 1 || phase == 2) ? 0 : (phase == 3) ? RST_NEAR_LIMIT : 1000;
            steady = (phase == 4);
            arm_follow();
            target = words_sent + PHASE_WORDS;
            count = 0;
            while (words_sent < target) begin
                count++;
                if (count % 25 == 0) begin
                    steady = (phase == 4) || ($urandom_range(0, 4) == 0);
                    arm_follow();
                end
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    send_event(CMD_W'($urandom_range(CMD_MODE, CMD_GESTURE)),
                               FLAG_W'($urandom_range(0, 3)));
                end else if (r == 5) begin
                    drain();
                    random_head(near);
                end else begin
                    random_head(near);
                end
            end
        end

        settle();
        $display("Run covered %0d event words, %0d drive results and %0d register settings.",
                 words_sent, drives_due, settings);
        if (mismatches == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
